FILE: rtl/mandelbrot_escape_time_macros.svh
// Assertion macros shared by the checker of the Mandelbrot escape-time block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mbe_pkg.sv
// Package for the Mandelbrot escape-time block: beat types, widths,
// register indexes and the 32-bit saturation helper. No dependencies.
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int WORD_W = 32;
  localparam int PIX_W  = 12;
  localparam int DIM_W  = 13;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 3;
  localparam int DVD_W  = PIX_W + WORD_W;  // magnitude of pixel * span

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SPAN_X          = 3'd2;
  localparam logic [IDX_W-1:0] REG_SPAN_Y          = 3'd3;
  localparam logic [IDX_W-1:0] REG_ORIGIN_X        = 3'd4;
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y        = 3'd5;
  localparam logic [IDX_W-1:0] REG_ITERATION_LIMIT = 3'd6;

  localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic [CNT_W-1:0] escape_count;
    logic             escaped;
  } res_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > Q_MAX) begin
      r = Q_MAX[WORD_W-1:0];
    end else if (v < Q_MIN) begin
      r = Q_MIN[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/mbe_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
// Depends on mbe_pkg for the word width.
`timescale 1ns / 1ps

module mbe_mul (
  input  logic                                clk,
  input  logic signed [mbe_pkg::WORD_W-1:0]   op_a,
  input  logic signed [mbe_pkg::WORD_W-1:0]   op_b,
  output logic signed [2*mbe_pkg::WORD_W-1:0] prod
);
  import mbe_pkg::*;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

FILE: rtl/mbe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; the top level supplies widths from mbe_pkg.
`timescale 1ns / 1ps

module mbe_div #(
  parameter int DVD_W = 44,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int CW = $clog2(DVD_W + 1);

  logic             run;
  logic [CW-1:0]    cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic             ge;
  logic [DVS_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[DVD_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DVD_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (run) begin
      rem <= rem_next;
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/mandelbrot_escape_time.sv
// Mandelbrot escape-time evaluator: maps a pixel to c and iterates z = z*z + c.
// Each pixel runs two mapping passes (x, then y), each a product on the shared multiplier
// and a division on the 44-step serial divider, then k iterations of the states SQA, SQB,
// MAB and UPD on the shared multiplier (k at most iteration_limit, 0 when the limit is 0).
// One pixel at a time: start is taken the cycle after the result strobe.
// Synchronous reset restores the register defaults and idles; the receiver cannot stall.
`timescale 1ns / 1ps

module mandelbrot_escape_time #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  mbe_pkg::pix_t                pixel,
  output logic                         done,
  output mbe_pkg::res_t                result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mbe_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mbe_pkg::WORD_W-1:0]   cfg_data
);
  import mbe_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_DIVGO   = 4'd2;
  localparam logic [3:0] S_DIVWAIT = 4'd3;
  localparam logic [3:0] S_SQA     = 4'd4;
  localparam logic [3:0] S_SQB     = 4'd5;
  localparam logic [3:0] S_MAB     = 4'd6;
  localparam logic [3:0] S_UPD     = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  localparam logic signed [63:0] BOUND = 64'sd16 <<< FRAC_BITS;

  // Configuration registers.
  logic [DIM_W-1:0]         image_width;
  logic [DIM_W-1:0]         image_height;
  logic signed [WORD_W-1:0] span_x;
  logic signed [WORD_W-1:0] span_y;
  logic signed [WORD_W-1:0] origin_x;
  logic signed [WORD_W-1:0] origin_y;
  logic [CNT_W-1:0]         iteration_limit;

  logic [3:0]               state;
  logic                     axis;     // 0 while mapping x, 1 while mapping y
  pix_t                     pix_r;
  logic                     neg_r;
  logic signed [WORD_W-1:0] cx;
  logic signed [WORD_W-1:0] cy;
  logic signed [WORD_W-1:0] a;
  logic signed [WORD_W-1:0] b;
  logic signed [WORD_W-1:0] aa;
  logic signed [WORD_W-1:0] bb;
  logic [CNT_W-1:0]         n;
  res_t                     result_r;

  logic signed [WORD_W-1:0]   op_a;
  logic signed [WORD_W-1:0]   op_b;
  logic signed [2*WORD_W-1:0] prod;

  logic                     div_start;
  logic                     div_done;
  logic [DVD_W-1:0]         div_mag;
  logic [DVD_W-1:0]         quotient;
  logic [DIM_W-1:0]         dim_raw;
  logic [DIM_W-1:0]         dim_eff;

  logic signed [DVD_W+1:0]  q_s;
  logic signed [DVD_W+1:0]  map_sum;
  logic signed [WORD_W-1:0] map_org;
  logic signed [WORD_W-1:0] map_val;

  logic signed [WORD_W-1:0] sq_val;
  logic signed [WORD_W-1:0] twoab;
  logic signed [63:0]       aa64;
  logic signed [63:0]       bb64;
  logic signed [63:0]       cx64;
  logic signed [63:0]       cy64;
  logic signed [63:0]       tab64;
  logic signed [WORD_W-1:0] a_next;
  logic signed [WORD_W-1:0] b_next;
  logic                     esc;
  logic [CNT_W-1:0]         n_next;

  mbe_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  mbe_div #(
    .DVD_W (DVD_W),
    .DVS_W (DIM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (dim_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // Operand select for the shared multiplier.
  always_comb begin
    case (state)
      S_MUL: begin
        op_a = $signed({{(WORD_W-PIX_W){1'b0}}, axis ? pix_r.pixel_y : pix_r.pixel_x});
        op_b = axis ? span_y : span_x;
      end
      S_SQA: begin
        op_a = a;
        op_b = a;
      end
      S_SQB: begin
        op_a = b;
        op_b = b;
      end
      default: begin
        op_a = a;
        op_b = b;
      end
    endcase
  end

  // Mapping datapath: divide |pixel * span| by the clamped dimension, then add origin.
  always_comb begin
    dim_raw = axis ? image_height : image_width;
    if (dim_raw == '0) begin
      dim_eff = DIM_W'(1);
    end else if (int'(dim_raw) > MAX_DIM) begin
      dim_eff = DIM_W'(MAX_DIM);
    end else begin
      dim_eff = dim_raw;
    end
    div_start = (state == S_DIVGO);
    div_mag   = prod[2*WORD_W-1] ? DVD_W'(~prod[DVD_W-1:0] + 1'b1) : prod[DVD_W-1:0];
    q_s       = neg_r ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    map_org   = axis ? origin_y : origin_x;
    map_sum   = q_s + {{(DVD_W+2-WORD_W){map_org[WORD_W-1]}}, map_org};
    map_val   = sat32({{(64-DVD_W-2){map_sum[DVD_W+1]}}, map_sum});
  end

  // Iteration datapath; prod holds a*a, b*b, then a*b on successive cycles.
  always_comb begin
    sq_val = sat32(prod >>> FRAC_BITS);
    twoab  = sat32(prod >>> (FRAC_BITS - 1));
    aa64   = 64'(aa);
    bb64   = 64'(bb);
    cx64   = 64'(cx);
    cy64   = 64'(cy);
    tab64  = 64'(twoab);
    a_next = sat32(aa64 - bb64 + cx64);
    b_next = sat32(tab64 + cy64);
    esc    = (aa64 + bb64) > BOUND;
    n_next = n + 1'b1;
  end

  // Sequencer and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      axis            <= 1'b0;
      image_width     <= DIM_W'(256);
      image_height    <= DIM_W'(256);
      span_x          <= 32'sd50331648;
      span_y          <= 32'sd50331648;
      origin_x        <= -32'sd33554432;
      origin_y        <= -32'sd25165824;
      iteration_limit <= CNT_W'(256);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:     image_width     <= cfg_data[DIM_W-1:0];
          REG_IMAGE_HEIGHT:    image_height    <= cfg_data[DIM_W-1:0];
          REG_SPAN_X:          span_x          <= cfg_data;
          REG_SPAN_Y:          span_y          <= cfg_data;
          REG_ORIGIN_X:        origin_x        <= cfg_data;
          REG_ORIGIN_Y:        origin_y        <= cfg_data;
          REG_ITERATION_LIMIT: iteration_limit <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            axis  <= 1'b0;
            state <= S_MUL;
          end
        end
        S_MUL:   state <= S_DIVGO;
        S_DIVGO: state <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (div_done) begin
            if (!axis) begin
              axis  <= 1'b1;
              state <= S_MUL;
            end else if (iteration_limit == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SQA;
            end
          end
        end
        S_SQA: state <= S_SQB;
        S_SQB: state <= S_MAB;
        S_MAB: state <= S_UPD;
        S_UPD: begin
          if (esc || n_next == iteration_limit) begin
            state <= S_DONE;
          end else begin
            state <= S_SQA;
          end
        end
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      pix_r <= pixel;
    end
    if (state == S_DIVGO) begin
      neg_r <= prod[2*WORD_W-1];
    end
    if (state == S_DIVWAIT && div_done) begin
      if (!axis) begin
        cx <= map_val;
        a  <= map_val;
      end else begin
        cy                    <= map_val;
        b                     <= map_val;
        n                     <= '0;
        result_r.escape_count <= '0;
        result_r.escaped      <= 1'b0;
      end
    end
    if (state == S_SQB) begin
      aa <= sq_val;
    end
    if (state == S_MAB) begin
      bb <= sq_val;
    end
    if (state == S_UPD) begin
      a <= a_next;
      b <= b_next;
      n <= n_next;
      if (esc) begin
        result_r.escape_count <= n;
        result_r.escaped      <= 1'b1;
      end else begin
        result_r.escape_count <= n_next;
        result_r.escaped      <= 1'b0;
      end
    end
  end

  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);
  assign result    = result_r;
  assign cfg_ready = 1'b1;

endmodule

FILE: rtl/mbe_checker.sv
// Port-level checker for the Mandelbrot escape-time block, bound to the top level.
// Depends on mbe_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_macros.svh"

module mbe_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input mbe_pkg::res_t result
);
  import mbe_pkg::*;

  `MBE_ASSERT_NOW(a_done_in_busy, done, busy, "result strobe while not busy")
  `MBE_ASSERT_NEXT(a_done_frees, done, !busy, "block still busy after result beat")
  `MBE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `MBE_ASSERT_NEXT(a_no_fast_done, !busy, !done, "result strobe without mapping time")
  `MBE_ASSERT_NOW(a_escape_count, done && result.escaped, busy, "escaped result outside busy")

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);
